// ----- rtl/core/qfc_pkg.sv -----
// Package for the quadratic form (chi-square) block.
// Holds the request types, operation and status codes, and the controller command type.
// No dependencies; every other file of the block but qfc_ram imports it.
`default_nettype none

package qfc_pkg;

    localparam int MAX_PARAMS_DEF = 64;
    localparam int PADDR_W = 3;
    localparam int PDATA_W = 32;
    localparam int NUM_PARAMS_W = 7;

    localparam logic REG_NUM_PARAMS = 1'b0;
    localparam logic [NUM_PARAMS_W-1:0] NUM_PARAMS_RST = 7'd64;
    localparam logic [NUM_PARAMS_W-1:0] COUNT_MAX = 7'd127;

    localparam logic signed [63:0] CHI2_MAX = 64'sh7FFF_FFFF_FFFF_FFFF;
    localparam logic signed [63:0] CHI2_MIN = 64'sh8000_0000_0000_0000;

    typedef enum logic [1:0] {
        OP_COV   = 2'd0,
        OP_PRIOR = 2'd1,
        OP_ELEM  = 2'd2
    } op_t;

    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_MISMATCH = 2'd1,
        ST_NOLOAD   = 2'd2
    } status_t;

    typedef enum logic [2:0] {
        K_NONE,
        K_CLEAR,
        K_LOAD_DI,
        K_MAC,
        K_CHUNK0,
        K_CHUNK1,
        K_CHUNK2
    } kind_t;

    typedef struct packed {
        logic [1:0]         operation;
        logic [5:0]         row_index;
        logic [5:0]         col_index;
        logic signed [31:0] value;
        logic               last;
    } item_req_t;

    typedef struct packed {
        logic signed [63:0] chi2;
        logic [1:0]         status;
    } result_req_t;

    typedef struct packed {
        kind_t kind;
        logic  cov_we;
        logic  prior_we;
        logic  val_cap;
        logic  diff_we;
        logic  res_ld;
        logic  res_ok;
    } cmd_t;

endpackage

`default_nettype wire

// ----- rtl/core/quadratic_form_chi2.sv -----
// Top level of the quadratic form block: configuration register port, controller and datapath.
// Depends on qfc_pkg, qfc_ctrl, qfc_dp and qfc_ram.
//
// The block computes the squared Mahalanobis distance chi2 = sum over i,j of d_i * d_j * Cinv(i,j),
// with d_i the difference of parameter element i from its prior, all in signed Q16.16, giving a
// floored and saturated Q32.32 result. The closing element of an N-element vector runs the double
// sum on the single shared 33 x 33 multiplier, which does one multiply-accumulate per cycle: for
// each matrix row it loads d_i, does N multiply-accumulates of d_j * Cinv(i,j), then three chunk
// steps that weight the row sum by d_i. A closing element with no matrix ever loaded, or with a
// vector length other than num_params (taken as 1 when zero and capped at MAX_PARAMS), returns a
// zero result and an error status. A closing element also waits for as long as the previous
// result has not been taken. Matrix and prior entries that were never written read as undefined
// values.
`default_nettype none

module quadratic_form_chi2 #(
    parameter int MAX_PARAMS = qfc_pkg::MAX_PARAMS_DEF
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          psel,
    input  wire logic                          penable,
    input  wire logic                          pwrite,
    input  wire logic [qfc_pkg::PADDR_W-1:0]   paddr,
    input  wire logic [qfc_pkg::PDATA_W-1:0]   pwdata,
    output logic      [qfc_pkg::PDATA_W-1:0]   prdata,
    output logic                               pready,
    input  wire logic                          item_valid,
    output logic                               item_ready,
    input  wire qfc_pkg::item_req_t            item,
    output logic                               result_valid,
    input  wire logic                          result_ready,
    output qfc_pkg::result_req_t               result
);

    import qfc_pkg::*;

    localparam int IdxW = $clog2(MAX_PARAMS);

    logic [NUM_PARAMS_W-1:0] num_params_reg;
    logic                    reg_sel;
    cmd_t                    cmd;
    logic [IdxW-1:0]         pos;
    logic [IdxW-1:0]         row_i;
    logic [IdxW-1:0]         col_j;
    logic signed [63:0]      chi2;
    logic [1:0]              status;

    assign pready  = 1'b1;
    assign reg_sel = (paddr[2] == REG_NUM_PARAMS);
    assign prdata  = reg_sel ? PDATA_W'(num_params_reg) : '0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            num_params_reg <= NUM_PARAMS_RST;
        end
        else if (psel && penable && pwrite && pready && reg_sel)
        begin
            num_params_reg <= pwdata[NUM_PARAMS_W-1:0];
        end
    end

    qfc_ctrl #(
        .MAX_PARAMS(MAX_PARAMS)
    ) u_ctrl (
        .clk         (clk),
        .rst_n       (rst_n),
        .item_valid  (item_valid),
        .item_ready  (item_ready),
        .item        (item),
        .num_params  (num_params_reg),
        .result_valid(result_valid),
        .result_ready(result_ready),
        .status      (status),
        .cmd         (cmd),
        .pos         (pos),
        .row_i       (row_i),
        .col_j       (col_j)
    );

    qfc_dp #(
        .MAX_PARAMS(MAX_PARAMS)
    ) u_dp (
        .clk  (clk),
        .rst_n(rst_n),
        .item (item),
        .cmd  (cmd),
        .pos  (pos),
        .row_i(row_i),
        .col_j(col_j),
        .chi2 (chi2)
    );

    assign result.chi2   = chi2;
    assign result.status = status;

endmodule

`default_nettype wire

// ----- rtl/core/qfc_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`default_nettype none

module qfc_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64,
    localparam int AW = $clog2(DEPTH)
) (
    input  wire logic             clk,
    input  wire logic             we,
    input  wire logic [AW-1:0]    waddr,
    input  wire logic [WIDTH-1:0] wdata,
    input  wire logic [AW-1:0]    raddr,
    output logic      [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        rdata <= mem[raddr];
    end

endmodule

`default_nettype wire

// ----- rtl/core/qfc_ctrl.sv -----
// Controller of the quadratic form block: input handshake, element counting,
// error checks, the row and column sequence of the double sum, and the result handshake.
// Depends on qfc_pkg.
`default_nettype none

module qfc_ctrl #(
    parameter int MAX_PARAMS = qfc_pkg::MAX_PARAMS_DEF,
    localparam int IdxW = $clog2(MAX_PARAMS)
) (
    input  wire logic                    clk,
    input  wire logic                    rst_n,
    input  wire logic                    item_valid,
    output logic                         item_ready,
    input  wire qfc_pkg::item_req_t      item,
    input  wire logic [6:0]              num_params,
    output logic                         result_valid,
    input  wire logic                    result_ready,
    output logic [1:0]                   status,
    output qfc_pkg::cmd_t                cmd,
    output logic [IdxW-1:0]              pos,
    output logic [IdxW-1:0]              row_i,
    output logic [IdxW-1:0]              col_j
);

    import qfc_pkg::*;

    localparam logic [6:0] SizeMax = (MAX_PARAMS > 127) ? 7'd127 : 7'(MAX_PARAMS);

    typedef enum logic [3:0] {
        S_IDLE,
        S_ELEM,
        S_CLEAR,
        S_ROW,
        S_MAC,
        S_GAP,
        S_CHUNK,
        S_TAIL,
        S_DONE
    } state_t;

    state_t          state_reg;
    logic [6:0]      count_reg;
    logic            last_reg;
    logic            loaded_reg;
    logic [IdxW-1:0] i_reg;
    logic [IdxW-1:0] j_reg;
    logic [1:0]      k_reg;
    logic            tail_reg;
    status_t         stat_reg;
    logic            res_ok_reg;
    status_t         res_status_reg;
    logic            out_valid_reg;

    logic       accept;
    logic       cov_ok;
    logic       prior_ok;
    logic [6:0] size;
    logic [6:0] last_idx;
    logic       row_last;
    logic       col_last;
    logic       pos_fits;
    logic       size_match;
    logic       out_free;

    always_comb
    begin
        if (num_params == 7'd0)
        begin
            size = 7'd1;
        end
        else if (num_params > SizeMax)
        begin
            size = SizeMax;
        end
        else
        begin
            size = num_params;
        end
    end

    assign last_idx   = size - 7'd1;
    assign row_last   = int'(i_reg) == int'(last_idx);
    assign col_last   = int'(j_reg) == int'(last_idx);
    assign pos_fits   = int'(count_reg) < MAX_PARAMS;
    assign size_match = (int'(count_reg) + 1) == int'(size);
    assign out_free   = !out_valid_reg || result_ready;

    assign item_ready = (state_reg == S_IDLE);
    assign accept     = item_valid && item_ready;
    assign cov_ok     = (int'(item.row_index) < MAX_PARAMS) && (int'(item.col_index) < MAX_PARAMS);
    assign prior_ok   = int'(item.row_index) < MAX_PARAMS;

    always_comb
    begin
        cmd          = '0;
        cmd.kind     = K_NONE;
        cmd.cov_we   = accept && (item.operation == OP_COV) && cov_ok;
        cmd.prior_we = accept && (item.operation == OP_PRIOR) && prior_ok;
        cmd.val_cap  = accept && (item.operation == OP_ELEM);
        cmd.diff_we  = (state_reg == S_ELEM) && pos_fits;
        cmd.res_ld   = (state_reg == S_DONE) && out_free;
        cmd.res_ok   = res_ok_reg;
        unique case (state_reg)
            S_CLEAR: cmd.kind = K_CLEAR;
            S_ROW:   cmd.kind = K_LOAD_DI;
            S_MAC:   cmd.kind = K_MAC;
            S_CHUNK:
            begin
                priority if (k_reg == 2'd0)
                begin
                    cmd.kind = K_CHUNK0;
                end
                else if (k_reg == 2'd1)
                begin
                    cmd.kind = K_CHUNK1;
                end
                else
                begin
                    cmd.kind = K_CHUNK2;
                end
            end
            default: cmd.kind = K_NONE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            count_reg      <= '0;
            last_reg       <= 1'b0;
            loaded_reg     <= 1'b0;
            i_reg          <= '0;
            j_reg          <= '0;
            k_reg          <= '0;
            tail_reg       <= 1'b0;
            stat_reg       <= ST_OK;
            res_ok_reg     <= 1'b0;
            res_status_reg <= ST_OK;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            if ((state_reg == S_DONE) && out_free)
            begin
                out_valid_reg  <= 1'b1;
                res_status_reg <= stat_reg;
            end
            else if (result_ready)
            begin
                out_valid_reg <= 1'b0;
            end

            unique case (state_reg)
                S_IDLE:
                begin
                    if (cmd.cov_we)
                    begin
                        loaded_reg <= 1'b1;
                    end
                    if (cmd.val_cap)
                    begin
                        last_reg  <= item.last;
                        state_reg <= S_ELEM;
                    end
                end
                S_ELEM:
                begin
                    if (!last_reg)
                    begin
                        if (count_reg != COUNT_MAX)
                        begin
                            count_reg <= count_reg + 7'd1;
                        end
                        state_reg <= S_IDLE;
                    end
                    else
                    begin
                        count_reg <= '0;
                        priority if (!loaded_reg)
                        begin
                            stat_reg   <= ST_NOLOAD;
                            res_ok_reg <= 1'b0;
                            state_reg  <= S_DONE;
                        end
                        else if (!size_match)
                        begin
                            stat_reg   <= ST_MISMATCH;
                            res_ok_reg <= 1'b0;
                            state_reg  <= S_DONE;
                        end
                        else
                        begin
                            stat_reg   <= ST_OK;
                            res_ok_reg <= 1'b1;
                            i_reg      <= '0;
                            state_reg  <= S_CLEAR;
                        end
                    end
                end
                S_CLEAR:
                begin
                    state_reg <= S_ROW;
                end
                S_ROW:
                begin
                    j_reg     <= '0;
                    state_reg <= S_MAC;
                end
                S_MAC:
                begin
                    if (col_last)
                    begin
                        state_reg <= S_GAP;
                    end
                    else
                    begin
                        j_reg <= j_reg + 1'b1;
                    end
                end
                S_GAP:
                begin
                    k_reg     <= '0;
                    state_reg <= S_CHUNK;
                end
                S_CHUNK:
                begin
                    if (k_reg == 2'd2)
                    begin
                        if (row_last)
                        begin
                            tail_reg  <= 1'b0;
                            state_reg <= S_TAIL;
                        end
                        else
                        begin
                            i_reg     <= i_reg + 1'b1;
                            state_reg <= S_ROW;
                        end
                    end
                    else
                    begin
                        k_reg <= k_reg + 2'd1;
                    end
                end
                S_TAIL:
                begin
                    if (tail_reg)
                    begin
                        state_reg <= S_DONE;
                    end
                    else
                    begin
                        tail_reg <= 1'b1;
                    end
                end
                S_DONE:
                begin
                    if (out_free)
                    begin
                        state_reg <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assign result_valid = out_valid_reg;
    assign status       = res_status_reg;
    assign pos          = IdxW'(count_reg);
    assign row_i        = i_reg;
    assign col_j        = j_reg;

endmodule

`default_nettype wire

// ----- rtl/core/qfc_dp.sv -----
// Datapath of the quadratic form block: matrix, prior and difference memories,
// one shared 33 x 33 multiplier, row sum and total accumulator, result saturation.
// Depends on qfc_pkg and qfc_ram.
`default_nettype none

module qfc_dp #(
    parameter int MAX_PARAMS = qfc_pkg::MAX_PARAMS_DEF,
    localparam int IdxW = $clog2(MAX_PARAMS)
) (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire qfc_pkg::item_req_t item,
    input  wire qfc_pkg::cmd_t      cmd,
    input  wire logic [IdxW-1:0]    pos,
    input  wire logic [IdxW-1:0]    row_i,
    input  wire logic [IdxW-1:0]    col_j,
    output logic signed [63:0]      chi2
);

    import qfc_pkg::*;

    localparam int SumW  = 65 + IdxW;
    localparam int AccW  = 97 + 2 * IdxW;
    localparam int Depth = 1 << IdxW;

    logic [31:0]            cov_rdata;
    logic [31:0]            prior_rdata;
    logic [32:0]            diff_rdata;
    logic signed [32:0]     diff_wdata;
    logic [IdxW-1:0]        diff_raddr;

    kind_t                  kind_b_reg;
    kind_t                  kind_c_reg;
    logic signed [31:0]     val_reg;
    logic signed [32:0]     di_reg;
    logic signed [65:0]     prod_reg;
    logic signed [SumW-1:0] s_reg;
    logic signed [AccW-1:0] acc_reg;
    logic signed [63:0]     chi2_reg;

    logic signed [32:0]     opa;
    logic signed [32:0]     opb;
    logic signed [SumW-65:0] s_top;
    logic signed [AccW-1:0] prod_ext;
    logic [AccW-80:0]       acc_high;
    logic signed [63:0]     sat;

    qfc_ram #(
        .WIDTH(32),
        .DEPTH(Depth * Depth)
    ) u_cov_ram (
        .clk  (clk),
        .we   (cmd.cov_we),
        .waddr({IdxW'(item.row_index), IdxW'(item.col_index)}),
        .wdata(item.value),
        .raddr({row_i, col_j}),
        .rdata(cov_rdata)
    );

    qfc_ram #(
        .WIDTH(32),
        .DEPTH(Depth)
    ) u_prior_ram (
        .clk  (clk),
        .we   (cmd.prior_we),
        .waddr(IdxW'(item.row_index)),
        .wdata(item.value),
        .raddr(pos),
        .rdata(prior_rdata)
    );

    assign diff_wdata = 33'(val_reg) - 33'($signed(prior_rdata));
    assign diff_raddr = (cmd.kind == K_LOAD_DI) ? row_i : col_j;

    qfc_ram #(
        .WIDTH(33),
        .DEPTH(Depth)
    ) u_diff_ram (
        .clk  (clk),
        .we   (cmd.diff_we),
        .waddr(pos),
        .wdata(diff_wdata),
        .raddr(diff_raddr),
        .rdata(diff_rdata)
    );

    assign s_top = s_reg[SumW-1:64];

    always_comb
    begin
        opa = (kind_b_reg == K_MAC) ? $signed(diff_rdata) : di_reg;
        unique case (kind_b_reg)
            K_MAC:    opb = 33'($signed(cov_rdata));
            K_CHUNK0: opb = {1'b0, s_reg[31:0]};
            K_CHUNK1: opb = {1'b0, s_reg[63:32]};
            K_CHUNK2: opb = 33'(s_top);
            default:  opb = '0;
        endcase
    end

    assign prod_ext = AccW'(prod_reg);
    assign acc_high = acc_reg[AccW-1:79];

    always_comb
    begin
        if ((&acc_high) || !(|acc_high))
        begin
            sat = acc_reg[79:16];
        end
        else if (acc_reg[AccW-1])
        begin
            sat = CHI2_MIN;
        end
        else
        begin
            sat = CHI2_MAX;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            kind_b_reg <= K_NONE;
            kind_c_reg <= K_NONE;
        end
        else
        begin
            kind_b_reg <= cmd.kind;
            kind_c_reg <= kind_b_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.val_cap)
        begin
            val_reg <= item.value;
        end
        if (kind_b_reg == K_LOAD_DI)
        begin
            di_reg <= $signed(diff_rdata);
        end
        prod_reg <= opa * opb;
        unique case (kind_c_reg)
            K_CLEAR:   acc_reg <= '0;
            K_LOAD_DI: s_reg   <= '0;
            K_MAC:     s_reg   <= s_reg + SumW'(prod_reg);
            K_CHUNK0:  acc_reg <= acc_reg + prod_ext;
            K_CHUNK1:  acc_reg <= acc_reg + (prod_ext <<< 32);
            K_CHUNK2:  acc_reg <= acc_reg + (prod_ext <<< 64);
            default:
            begin
            end
        endcase
        if (cmd.res_ld)
        begin
            chi2_reg <= cmd.res_ok ? sat : '0;
        end
    end

    assign chi2 = chi2_reg;

endmodule

`default_nettype wire

// ----- rtl/core/qfc_checker.sv -----
// Port-level assertions for the quadratic form block, attached to the top level by bind.
// Depends on qfc_pkg and quadratic_form_chi2.
`default_nettype none

module qfc_checker (
    input wire logic                        clk,
    input wire logic                        rst_n,
    input wire logic                        psel,
    input wire logic                        pwrite,
    input wire logic [qfc_pkg::PDATA_W-1:0] prdata,
    input wire logic                        item_valid,
    input wire logic                        item_ready,
    input wire qfc_pkg::item_req_t          item,
    input wire logic                        result_valid,
    input wire logic                        result_ready,
    input wire qfc_pkg::result_req_t        result
);

    import qfc_pkg::*;

    a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> (result.status == ST_OK || result.status == ST_MISMATCH ||
                          result.status == ST_NOLOAD))
        else $error("result status outside the defined codes");

    a_error_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && result.status != ST_OK) |-> (result.chi2 == 64'sd0))
        else $error("error result carries a nonzero chi2");

    a_result_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && !result_ready) |=> (result_valid && $stable(result)))
        else $error("stalled result changed or dropped");

    a_elem_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (item_valid && item_ready && item.operation == OP_ELEM) |=> !item_ready)
        else $error("element request accepted while the difference write is pending");

    a_read_width: assert property (@(posedge clk) disable iff (!rst_n)
        (psel && !pwrite) |-> (prdata[PDATA_W-1:NUM_PARAMS_W] == '0))
        else $error("register read returns bits beyond the register width");

endmodule

bind quadratic_form_chi2 qfc_checker u_qfc_checker (.*);

`default_nettype wire

// ----- tb/qfc_tb_pkg.sv -----
`timescale 1ns / 100ps
// Scoreboard for the quadratic form block: keeps its own matrix, prior and difference
// tables and predicts chi2 and status for each closing parameter element. Depends on qfc_pkg.
package qfc_tb_pkg;

    import qfc_pkg::*;

    localparam int VEC_MAX = MAX_PARAMS_DEF;
    localparam logic [1:0] OP_IGNORED = 2'd3;
    localparam logic [PADDR_W-1:0] ADDR_NUM_PARAMS = '0;

    class chi2_scoreboard;
        logic [NUM_PARAMS_W-1:0] num_params;
        logic signed [31:0]      cov_store [VEC_MAX*VEC_MAX];
        logic signed [31:0]      prior_store [VEC_MAX];
        logic signed [32:0]      diff_store [VEC_MAX];
        int unsigned             elem_count;
        bit                      matrix_loaded;
        result_req_t             chi2_queue [$];
        int unsigned             errors;

        function new();
            num_params = NUM_PARAMS_RST;
            elem_count = 0;
            matrix_loaded = 1'b0;
            errors = 0;
        endfunction

        function void set_size(logic [NUM_PARAMS_W-1:0] value);
            num_params = value;
        endfunction

        function int unsigned active_size();
            if (num_params == 0)
                return 1;
            if (num_params > VEC_MAX)
                return VEC_MAX;
            return num_params;
        endfunction

        function int pending();
            return chi2_queue.size();
        endfunction

        function logic signed [63:0] quad_form(int unsigned n);
            logic signed [127:0] acc, di, dj, cij, shifted;
            int unsigned i, j;
            acc = '0;
            for (i = 0; i < n; i++)
                for (j = 0; j < n; j++)
                begin
                    di = diff_store[i];
                    dj = diff_store[j];
                    cij = cov_store[i * VEC_MAX + j];
                    acc = acc + di * dj * cij;
                end
            // Arithmetic shift floors the Q48.48 sum down to Q32.32.
            shifted = acc >>> 16;
            if (shifted > CHI2_MAX)
                return CHI2_MAX;
            if (shifted < CHI2_MIN)
                return CHI2_MIN;
            return shifted[63:0];
        endfunction

        function void note_request(item_req_t r);
            int unsigned pos, n;
            result_req_t res;
            case (r.operation)
                OP_COV:
                begin
                    cov_store[{r.row_index, r.col_index}] = r.value;
                    matrix_loaded = 1'b1;
                end
                OP_PRIOR:
                    prior_store[r.row_index] = r.value;
                OP_ELEM:
                begin
                    pos = elem_count;
                    n = active_size();
                    if (pos < VEC_MAX)
                        diff_store[pos] = $signed(r.value) - prior_store[pos];
                    if (elem_count < COUNT_MAX)
                        elem_count++;
                    if (r.last)
                    begin
                        elem_count = 0;
                        res.chi2 = '0;
                        if (!matrix_loaded)
                            res.status = ST_NOLOAD;
                        else if (pos + 1 != n)
                            res.status = ST_MISMATCH;
                        else
                        begin
                            res.status = ST_OK;
                            res.chi2 = quad_form(n);
                        end
                        chi2_queue.push_back(res);
                    end
                end
                default: ;
            endcase
        endfunction

        task report(string msg);
            $display("MISMATCH: %s", msg);
            errors++;
        endtask

        task check_result(result_req_t got);
            result_req_t want;
            if (chi2_queue.size() == 0)
            begin
                report($sformatf("unexpected result chi2=%h status=%0d", got.chi2, got.status));
                return;
            end
            want = chi2_queue.pop_front();
            if (got.chi2 !== want.chi2)
                report($sformatf("chi2 got %h expected %h", got.chi2, want.chi2));
            if (got.status !== want.status)
                report($sformatf("status got %0d expected %0d", got.status, want.status));
        endtask
    endclass

endpackage

// ----- tb/tb_top.sv -----
`timescale 1ns / 100ps
// Top-level testbench for quadratic_form_chi2: drives requests and register writes, checks
// every result against chi2_scoreboard. Depends on qfc_pkg, qfc_tb_pkg and the block itself.
module tb_top;

    import qfc_pkg::*;
    import qfc_tb_pkg::*;

    logic                clk = 1'b0;
    logic                rst_n = 1'b0;
    logic                psel = 1'b0;
    logic                penable = 1'b0;
    logic                pwrite = 1'b0;
    logic [PADDR_W-1:0]  paddr = '0;
    logic [PDATA_W-1:0]  pwdata = '0;
    logic [PDATA_W-1:0]  prdata;
    logic                pready;
    logic                item_valid = 1'b0;
    logic                item_ready;
    item_req_t           item = '0;
    logic                result_valid;
    logic                result_ready = 1'b0;
    result_req_t         result;

    chi2_scoreboard      sb;
    int                  send_idle = 21;
    int                  recv_idle = 87;
    int unsigned         item_total = 0;
    bit                  cov_set [VEC_MAX*VEC_MAX];
    bit                  prior_set [VEC_MAX];

    quadratic_form_chi2 uut (
        .clk          (clk),
        .rst_n        (rst_n),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .prdata       (prdata),
        .pready       (pready),
        .item_valid   (item_valid),
        .item_ready   (item_ready),
        .item         (item),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .result       (result)
    );

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        if (rst_n && result_valid && result_ready)
            sb.check_result(result);
        result_ready <= ($urandom_range(99) >= recv_idle);
    end

    function automatic logic [31:0] rand_value();
        int unsigned pick;
        pick = $urandom_range(99);
        if (pick < 45)
            return 32'($urandom_range(32'h0003_FFFF)) - 32'h0002_0000;
        if (pick < 65)
            return 32'($urandom_range(32'h01FF_FFFF)) - 32'h0100_0000;
        if (pick < 90)
            return $urandom;
        case ($urandom_range(3))
            0: return 32'h7FFF_FFFF;
            1: return 32'h8000_0000;
            2: return 32'h0000_0000;
            default: return 32'hFFFF_FFFF;
        endcase
    endfunction

    function automatic logic [NUM_PARAMS_W-1:0] pick_size();
        int unsigned pick;
        pick = $urandom_range(99);
        if (pick < 8)
            return '0;
        if (pick < 16)
            return NUM_PARAMS_W'($urandom_range(16, 9));
        return NUM_PARAMS_W'($urandom_range(8, 1));
    endfunction

    task automatic send_item(input logic [1:0] op, input logic [5:0] row,
                             input logic [5:0] col, input logic [31:0] value,
                             input logic last);
        item_req_t r;
        r.operation = op;
        r.row_index = row;
        r.col_index = col;
        r.value = value;
        r.last = last;
        if ($urandom_range(99) < send_idle)
        begin
            item_valid <= 1'b0;
            @(posedge clk);
            while ($urandom_range(99) < send_idle)
                @(posedge clk);
        end
        item_valid <= 1'b1;
        item <= r;
        @(posedge clk);
        while (!item_ready)
            @(posedge clk);
        sb.note_request(r);
        if (op == OP_COV)
            cov_set[{row, col}] = 1'b1;
        if (op == OP_PRIOR)
            prior_set[row] = 1'b1;
        if (op != OP_IGNORED)
            item_total++;
    endtask

    task automatic send_noise();
        send_item(OP_IGNORED, 6'($urandom), 6'($urandom), $urandom, 1'($urandom));
    endtask

    // Tables are filled just in time so that no element or double sum reads an unwritten entry.
    task automatic send_elem(input logic [31:0] value, input logic last);
        int unsigned pos, n, i, j;
        pos = sb.elem_count;
        n = sb.active_size();
        if ($urandom_range(19) == 0)
            send_noise();
        if (pos < VEC_MAX && !prior_set[pos])
            send_item(OP_PRIOR, 6'(pos), 6'($urandom), rand_value(), 1'($urandom));
        if (last && sb.matrix_loaded && pos + 1 == n)
            for (i = 0; i < n; i++)
                for (j = 0; j < n; j++)
                    if (!cov_set[i * VEC_MAX + j])
                        send_item(OP_COV, 6'(i), 6'(j), rand_value(), 1'($urandom));
        send_item(OP_ELEM, 6'($urandom), 6'($urandom), value, last);
    endtask

    task automatic send_vector(input int unsigned len);
        int unsigned k;
        for (k = 0; k < len; k++)
            send_elem(rand_value(), k == len - 1);
    endtask

    task automatic rand_load();
        int unsigned n;
        logic [5:0] row, col;
        n = sb.active_size();
        if ($urandom_range(3) != 0)
        begin
            row = 6'($urandom_range(n - 1));
            col = 6'($urandom_range(n - 1));
        end
        else
        begin
            row = 6'($urandom);
            col = 6'($urandom);
        end
        send_item($urandom_range(1) ? OP_COV : OP_PRIOR, row, col, rand_value(), 1'($urandom));
    endtask

    task automatic run_sequence();
        int unsigned n, pick;
        n = sb.active_size();
        pick = $urandom_range(99);
        if (pick < 60)
        begin
            repeat ($urandom_range(4))
                rand_load();
            send_vector(n);
        end
        else if (pick < 70 && n > 1)
            send_vector($urandom_range(n - 1, 1));
        else if (pick < 80)
            send_vector(n + $urandom_range(3, 1));
        else if (pick < 81)
            send_vector(COUNT_MAX + 3);
        else if (pick < 90)
            repeat ($urandom_range(3, 1))
                send_noise();
        else
            repeat ($urandom_range(6, 1))
                rand_load();
    endtask

    task automatic wait_idle();
        item_valid <= 1'b0;
        @(posedge clk);
        while (sb.pending() != 0)
            @(posedge clk);
        repeat (16)
            @(posedge clk);
    endtask

    task automatic write_size(input logic [NUM_PARAMS_W-1:0] size);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= ADDR_NUM_PARAMS;
        pwdata <= {25'($urandom), size};
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        psel <= 1'b0;
        penable <= 1'b0;
        sb.set_size(size);
    endtask

    initial
    begin
        int unsigned random_start, episode_start, done;
        sb = new();
        repeat (2)
            @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // A closing element before any matrix write reports no matrix loaded.
        send_item(OP_PRIOR, 6'd0, 6'd0, 32'h7FFF_FFFF, 1'b1);
        send_item(OP_IGNORED, 6'h3F, 6'h3F, 32'hFFFF_FFFF, 1'b1);
        send_elem(32'h0000_0000, 1'b1);
        wait_idle();
        write_size(7'd2);
        send_item(OP_PRIOR, 6'd1, 6'd0, 32'h8000_0000, 1'b0);
        send_elem(32'h0001_2345, 1'b0);
        send_elem(32'hFFFF_0000, 1'b1);
        send_item(OP_COV, 6'd0, 6'd0, 32'h7FFF_FFFF, 1'b0);
        send_item(OP_COV, 6'd0, 6'd1, 32'h8000_0000, 1'b0);
        send_item(OP_COV, 6'd1, 6'd0, 32'h0001_0000, 1'b0);
        send_item(OP_COV, 6'd1, 6'd1, 32'h0001_0000, 1'b1);
        send_item(OP_COV, 6'h3F, 6'h3F, 32'h0000_0000, 1'b0);
        send_item(OP_PRIOR, 6'h3F, 6'h2A, 32'h7FFF_FFFF, 1'b0);
        // Widest differences in both directions, then a negative saturation.
        send_elem(32'h8000_0000, 1'b0);
        send_elem(32'h7FFF_FFFF, 1'b1);
        send_item(OP_COV, 6'd0, 6'd0, 32'h8000_0000, 1'b0);
        send_elem(32'h8000_0000, 1'b0);
        send_elem(32'h8000_0000, 1'b1);
        send_item(OP_COV, 6'd0, 6'd0, 32'h0001_0000, 1'b0);
        send_item(OP_COV, 6'd0, 6'd1, 32'hFFFF_8000, 1'b0);
        send_item(OP_PRIOR, 6'd0, 6'd0, 32'h0000_8000, 1'b0);
        send_elem(32'h0001_8000, 1'b0);
        send_elem(32'h8000_8000, 1'b1);
        // Short and long vectors report a size mismatch.
        send_elem(32'h1234_5678, 1'b1);
        send_vector(3);

        random_start = item_total;
        while (item_total - random_start < 1600)
        begin
            done = item_total - random_start;
            if (done < 533)
            begin
                send_idle = 21;
                recv_idle = 87;
            end
            else if (done < 1066)
            begin
                send_idle = 87;
                recv_idle = 21;
            end
            else
            begin
                send_idle = 0;
                recv_idle = 0;
            end
            wait_idle();
            write_size(pick_size());
            episode_start = item_total;
            while (item_total - episode_start < 60 && item_total - random_start < 1600)
                run_sequence();
        end

        wait_idle();
        write_size(7'd127);
        send_vector(VEC_MAX + 1);
        send_vector(VEC_MAX - 1);
        wait_idle();
        write_size(7'd64);
        send_vector(10);

        wait_idle();
        repeat (200)
            @(posedge clk);
        if (sb.errors == 0)
            $display("quadratic_form_chi2 verification clean");
        else
            $display("quadratic_form_chi2 verification failed");
        $finish;
    end

    initial
    begin
        #2_000_000;
        $display("quadratic_form_chi2 verification failed");
        $finish;
    end

endmodule

// ----- filelist.f -----
rtl/core/qfc_pkg.sv
rtl/core/qfc_ram.sv
rtl/core/qfc_ctrl.sv
rtl/core/qfc_dp.sv
rtl/core/quadratic_form_chi2.sv
rtl/core/qfc_checker.sv
tb/qfc_tb_pkg.sv
tb/tb_top.sv
